// File: src/hsfe_pkg.sv
`default_nettype none

package hsfe_pkg;

    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_FLAG   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE = 1'd1;

    localparam logic [7:0]  FLAG_RESET   = 8'h7E;
    localparam logic [7:0]  ESCAPE_RESET = 8'h7D;
    localparam logic [7:0]  STUFF_XOR    = 8'h20;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h8408;

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] escape_byte;
    } cfg_t;

    // One classified input item; data_byte is already XORed when stuff is set.
    typedef struct packed {
        logic [7:0] command;
        logic [7:0] data_byte;
        logic       first;
        logic       last;
        logic       has_data;
        logic       stuff;
    } item_t;

    typedef enum logic [3:0] {
        STEP_FLAG_OPEN,
        STEP_CMD,
        STEP_CTRL,
        STEP_ESC,
        STEP_DATA,
        STEP_CRC_HI,
        STEP_CRC_LO,
        STEP_FLAG_CLOSE,
        STEP_DONE
    } step_t;

endpackage

`default_nettype wire

// File: src/hsfe_front.sv
`default_nettype none

module hsfe_front (
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_data_byte,
    input  wire logic [7:0]    s_command,
    input  wire logic          s_first,
    input  wire logic          s_last,
    input  wire logic          s_empty_req,
    input  wire hsfe_pkg::cfg_t cfg,
    output logic               q_push,
    input  wire logic          q_ready,
    output hsfe_pkg::item_t    q_item
);

    logic match;
    logic produces;

    always_comb begin
        match    = (s_data_byte == cfg.flag_byte) || (s_data_byte == cfg.escape_byte);
        produces = s_first || s_last || !s_empty_req;

        q_item.command   = s_command;
        q_item.first     = s_first;
        q_item.last      = s_last;
        q_item.has_data  = !s_empty_req;
        q_item.stuff     = !s_empty_req && match;
        q_item.data_byte = q_item.stuff ? (s_data_byte ^ hsfe_pkg::STUFF_XOR) : s_data_byte;
    end

    // An empty item with neither first nor last is taken and dropped here.
    assign s_ready = q_ready;
    assign q_push  = s_valid && q_ready && produces;

endmodule

`default_nettype wire

// File: src/hsfe_queue.sv
`default_nettype none

module hsfe_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    output logic                 in_ready,
    input  wire hsfe_pkg::item_t in_item,
    output logic                 out_valid,
    input  wire logic            pop,
    output hsfe_pkg::item_t      out_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    hsfe_pkg::item_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign do_push   = push && in_ready;
    assign do_pop    = pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// File: src/hsfe_back.sv
`default_nettype none

module hsfe_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire hsfe_pkg::cfg_t  cfg,
    input  wire logic            q_valid,
    output logic                 q_pop,
    input  wire hsfe_pkg::item_t q_item,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [7:0]           m_out_byte,
    output logic                 m_frame_end,
    output logic                 m_last_of_run
);

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ hsfe_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic hsfe_pkg::step_t after_payload(input hsfe_pkg::item_t it);
        if (it.has_data) begin
            return it.stuff ? hsfe_pkg::STEP_ESC : hsfe_pkg::STEP_DATA;
        end
        return it.last ? hsfe_pkg::STEP_CRC_HI : hsfe_pkg::STEP_DONE;
    endfunction

    function automatic hsfe_pkg::step_t first_step(input hsfe_pkg::item_t it);
        return it.first ? hsfe_pkg::STEP_FLAG_OPEN : after_payload(it);
    endfunction

    hsfe_pkg::item_t cur_reg, cur_next;
    logic            cur_valid_reg, cur_valid_next;
    hsfe_pkg::step_t step_reg, step_next, step_after;
    logic [15:0]     crc_reg, crc_next;
    logic            m_valid_reg, m_valid_next;
    logic [7:0]      m_byte_reg, m_byte_next;
    logic            m_end_reg, m_end_next;
    logic            m_lor_reg, m_lor_next;
    logic [7:0]      byte_sel;
    logic            end_sel;
    logic            feed_crc;
    logic            advance, is_final;

    always_comb begin
        byte_sel   = cfg.flag_byte;
        end_sel    = 1'b0;
        feed_crc   = 1'b0;
        step_after = hsfe_pkg::STEP_DONE;
        case (step_reg)
            hsfe_pkg::STEP_FLAG_OPEN: begin
                byte_sel   = cfg.flag_byte;
                step_after = hsfe_pkg::STEP_CMD;
            end
            hsfe_pkg::STEP_CMD: begin
                byte_sel   = cur_reg.command;
                feed_crc   = 1'b1;
                step_after = hsfe_pkg::STEP_CTRL;
            end
            hsfe_pkg::STEP_CTRL: begin
                byte_sel   = cfg.escape_byte;
                feed_crc   = 1'b1;
                step_after = after_payload(cur_reg);
            end
            hsfe_pkg::STEP_ESC: begin
                byte_sel   = cfg.escape_byte;
                feed_crc   = 1'b1;
                step_after = hsfe_pkg::STEP_DATA;
            end
            hsfe_pkg::STEP_DATA: begin
                byte_sel   = cur_reg.data_byte;
                feed_crc   = 1'b1;
                step_after = cur_reg.last ? hsfe_pkg::STEP_CRC_HI : hsfe_pkg::STEP_DONE;
            end
            hsfe_pkg::STEP_CRC_HI: begin
                byte_sel   = ~crc_reg[15:8];
                step_after = hsfe_pkg::STEP_CRC_LO;
            end
            hsfe_pkg::STEP_CRC_LO: begin
                byte_sel   = ~crc_reg[7:0];
                step_after = hsfe_pkg::STEP_FLAG_CLOSE;
            end
            hsfe_pkg::STEP_FLAG_CLOSE: begin
                byte_sel   = cfg.flag_byte;
                end_sel    = 1'b1;
                step_after = hsfe_pkg::STEP_DONE;
            end
            default: begin
                step_after = hsfe_pkg::STEP_DONE;
            end
        endcase

        // The opening flag restarts the CRC, the closing flag rearms it.
        if (feed_crc) begin
            crc_next = crc_feed(crc_reg, byte_sel);
        end else if (step_reg == hsfe_pkg::STEP_FLAG_OPEN ||
                     step_reg == hsfe_pkg::STEP_FLAG_CLOSE) begin
            crc_next = hsfe_pkg::CRC_INIT;
        end else begin
            crc_next = crc_reg;
        end
    end

    always_comb begin
        advance  = cur_valid_reg && (!m_valid_reg || m_ready);
        is_final = (step_after == hsfe_pkg::STEP_DONE);
        q_pop    = q_valid && (!cur_valid_reg || (advance && is_final));

        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_end_next   = m_end_reg;
        m_lor_next   = m_lor_reg;
        if (advance) begin
            m_valid_next = 1'b1;
            m_byte_next  = byte_sel;
            m_end_next   = end_sel;
            m_lor_next   = is_final;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (q_pop) begin
            cur_next       = q_item;
            cur_valid_next = 1'b1;
            step_next      = first_step(q_item);
        end else if (advance && is_final) begin
            cur_valid_next = 1'b0;
            step_next      = hsfe_pkg::STEP_DONE;
        end else if (advance) begin
            step_next = step_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= hsfe_pkg::STEP_DONE;
            crc_reg       <= hsfe_pkg::CRC_INIT;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            m_valid_reg   <= m_valid_next;
            if (advance) begin
                crc_reg <= crc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        m_byte_reg <= m_byte_next;
        m_end_reg  <= m_end_next;
        m_lor_reg  <= m_lor_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_byte_reg;
    assign m_frame_end   = m_end_reg;
    assign m_last_of_run = m_lor_reg;

endmodule

`default_nettype wire

// File: src/hdlc_style_frame_encoder_top.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    data_byte, command, first, last, empty_req
// m_        out        m_valid / m_ready    out_byte, frame_end, last_of_run
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The back sequencer emits one output byte per cycle while a stalled m_ready does
// not hold it; an item has 1 to 8 result bytes, with 1 or 2 for a payload item.
// Reset restores flag 0x7E, escape 0x7D, the CRC to 0xFFFF and empties the queue.
// A stalled m_ready holds the output register; the item queue keeps taking input
// until it is full. Configuration writes are taken in any cycle.

module hdlc_style_frame_encoder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [7:0]                       s_data_byte,
    input  wire logic [7:0]                       s_command,
    input  wire logic                             s_first,
    input  wire logic                             s_last,
    input  wire logic                             s_empty_req,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [7:0]                            m_out_byte,
    output logic                                  m_frame_end,
    output logic                                  m_last_of_run,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [hsfe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                       cfg_data
);

    hsfe_pkg::cfg_t  cfg_reg, cfg_next;
    hsfe_pkg::item_t front_item, queue_item;
    logic            q_push, q_ready, q_valid, q_pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                hsfe_pkg::REG_FLAG:   cfg_next.flag_byte   = cfg_data;
                hsfe_pkg::REG_ESCAPE: cfg_next.escape_byte = cfg_data;
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flag_byte   <= hsfe_pkg::FLAG_RESET;
            cfg_reg.escape_byte <= hsfe_pkg::ESCAPE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    hsfe_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_command   (s_command),
        .s_first     (s_first),
        .s_last      (s_last),
        .s_empty_req (s_empty_req),
        .cfg         (cfg_reg),
        .q_push      (q_push),
        .q_ready     (q_ready),
        .q_item      (front_item)
    );

    hsfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .in_ready  (q_ready),
        .in_item   (front_item),
        .out_valid (q_valid),
        .pop       (q_pop),
        .out_item  (queue_item)
    );

    hsfe_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (queue_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_frame_end   (m_frame_end),
        .m_last_of_run (m_last_of_run)
    );

endmodule

`default_nettype wire
